/* hdl/wav_pkg.sv */
// shared types and constants for the riff/wave pcm16 deframer
package wav_pkg;

    // chunk tags as they appear little-endian in the byte collector
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    // format header requirements
    localparam logic [15:0] FMT_CODE_PCM  = 16'd1;
    localparam logic [15:0] FMT_BITS_16   = 16'd16;
    localparam logic [31:0] FMT_BODY_LEN  = 32'd16;
    localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;
    localparam logic [31:0] WAVE_TAG_LEN  = 32'd4;

    // parse status codes
    localparam logic [2:0] STS_HEADER    = 3'd0;
    localparam logic [2:0] STS_DATA      = 3'd1;
    localparam logic [2:0] STS_DATA_DONE = 3'd2;
    localparam logic [2:0] STS_INVALID   = 3'd3;
    localparam logic [2:0] STS_TRUNCATED = 3'd4;

    // one result word
    typedef struct packed {
        logic [15:0] pcm_sample;
        logic        pcm_valid;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [2:0]  parse_status;
    } t_result;

endpackage

/* hdl/wav_parse.sv */
// parser state and next-state logic for one file byte
module wav_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output wav_pkg::t_result o_result
);

    typedef enum logic [3:0] {
        PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_TAG, PH_CHUNK_SIZE,
        PH_FMT_BODY, PH_SKIP, PH_DATA, PH_DONE, PH_INVALID
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER, KIND_FMT, KIND_DATA
    } t_kind;

    t_phase      r_phase, n_phase;
    t_kind       r_kind, n_kind;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_riff, n_riff;
    logic [32:0] r_chunk, n_chunk;
    logic        r_seen, n_seen;
    logic [15:0] r_code, n_code;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_data, n_data;
    logic [7:0]  r_hold, n_hold;
    logic        r_held, n_held;
    logic [3:0]  r_body, n_body;

    logic [31:0] shifted;
    logic        field_done;
    logic [31:0] riff_m8;
    logic [31:0] clamped;
    logic [31:0] extra;
    logic [32:0] chunk_dec;
    logic [31:0] data_dec;
    logic [2:0]  status;
    logic        fmt_ok;

    // byte collector and chunk size clamp
    assign shifted    = {i_byte, r_shift[31:8]};
    assign field_done = (r_cnt == 2'd3);
    assign riff_m8    = r_riff - wav_pkg::CHUNK_HDR_LEN;
    assign clamped    = (shifted > riff_m8) ? riff_m8 : shifted;
    assign extra      = clamped - wav_pkg::FMT_BODY_LEN;
    assign chunk_dec  = (r_chunk != '0) ? r_chunk - 33'd1 : r_chunk;
    assign data_dec   = (r_data != '0) ? r_data - 32'd1 : r_data;
    assign fmt_ok     = (r_code == wav_pkg::FMT_CODE_PCM) && (n_bits == wav_pkg::FMT_BITS_16)
                        && (r_chan != '0) && (r_rate != '0);

    // next state for one byte
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_riff  = r_riff;
        n_chunk = r_chunk;
        n_seen  = r_seen;
        n_code  = r_code;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_bits  = r_bits;
        n_data  = r_data;
        n_hold  = r_hold;
        n_held  = r_held;
        n_body  = r_body;
        o_result.pcm_sample = '0;
        o_result.pcm_valid  = 1'b0;

        unique case (r_phase)
            PH_RIFF_TAG: begin
                n_shift = shifted;
                n_cnt   = r_cnt + 2'd1;
                if (field_done) begin
                    n_riff  = (shifted != wav_pkg::ID_RIFF) ? 32'd1 : 32'd0;
                    n_phase = PH_RIFF_SIZE;
                end
            end
            PH_RIFF_SIZE: begin
                n_shift = shifted;
                n_cnt   = r_cnt + 2'd1;
                if (field_done) begin
                    if (r_riff != '0 || shifted < wav_pkg::WAVE_TAG_LEN) begin
                        n_phase = PH_INVALID;
                    end else begin
                        n_riff  = shifted - wav_pkg::WAVE_TAG_LEN;
                        n_phase = PH_WAVE_TAG;
                    end
                end
            end
            PH_WAVE_TAG: begin
                n_shift = shifted;
                n_cnt   = r_cnt + 2'd1;
                if (field_done) begin
                    if (shifted != wav_pkg::ID_WAVE) begin
                        n_phase = PH_INVALID;
                    end else begin
                        n_phase = (r_riff > wav_pkg::CHUNK_HDR_LEN) ? PH_CHUNK_TAG : PH_INVALID;
                    end
                end
            end
            PH_CHUNK_TAG: begin
                n_shift = shifted;
                n_cnt   = r_cnt + 2'd1;
                if (field_done) begin
                    if (shifted == wav_pkg::ID_FMT) begin
                        n_kind = KIND_FMT;
                    end else if (shifted == wav_pkg::ID_DATA) begin
                        n_kind = KIND_DATA;
                    end else begin
                        n_kind = KIND_OTHER;
                    end
                    n_phase = PH_CHUNK_SIZE;
                end
            end
            PH_CHUNK_SIZE: begin
                n_shift = shifted;
                n_cnt   = r_cnt + 2'd1;
                if (field_done) begin
                    n_riff = riff_m8 - clamped;
                    case (r_kind)
                        KIND_FMT: begin
                            if (clamped < wav_pkg::FMT_BODY_LEN) begin
                                n_phase = PH_INVALID;
                            end else begin
                                n_seen  = 1'b0;
                                n_body  = '0;
                                n_chunk = {1'b0, extra} + {32'd0, extra[0]};
                                n_phase = PH_FMT_BODY;
                            end
                        end
                        KIND_DATA: begin
                            if (!r_seen) begin
                                n_phase = PH_INVALID;
                            end else begin
                                n_data  = clamped;
                                n_held  = 1'b0;
                                n_phase = (clamped == '0) ? PH_DONE : PH_DATA;
                            end
                        end
                        default: begin
                            n_chunk = {1'b0, clamped} + {32'd0, clamped[0]};
                            if (clamped == '0) begin
                                // empty chunk: riff count is just minus the header
                                n_phase = (riff_m8 > wav_pkg::CHUNK_HDR_LEN) ? PH_CHUNK_TAG
                                                                             : PH_INVALID;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    endcase
                end
            end
            PH_FMT_BODY: begin
                n_shift = shifted;
                case (r_body)
                    4'd1:    n_code = shifted[31:16];
                    4'd3:    n_chan = shifted[31:16];
                    4'd7:    n_rate = shifted;
                    4'd15:   n_bits = shifted[31:16];
                    default: ;
                endcase
                if (r_body == 4'd15) begin
                    n_body = '0;
                    if (!fmt_ok) begin
                        n_phase = PH_INVALID;
                    end else begin
                        n_seen = 1'b1;
                        if (r_chunk == '0) begin
                            n_phase = (r_riff > wav_pkg::CHUNK_HDR_LEN) ? PH_CHUNK_TAG
                                                                        : PH_INVALID;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end else begin
                    n_body = r_body + 4'd1;
                end
            end
            PH_SKIP: begin
                n_chunk = chunk_dec;
                if (chunk_dec == '0) begin
                    n_phase = (r_riff > wav_pkg::CHUNK_HDR_LEN) ? PH_CHUNK_TAG : PH_INVALID;
                end
            end
            PH_DATA: begin
                if (r_held) begin
                    o_result.pcm_sample = {i_byte, r_hold};
                    o_result.pcm_valid  = 1'b1;
                    n_held = 1'b0;
                end else begin
                    n_hold = i_byte;
                    n_held = 1'b1;
                end
                n_data = data_dec;
                // an odd trailing byte is dropped here
                if (data_dec == '0) begin
                    n_held  = 1'b0;
                    n_phase = PH_DONE;
                end
            end
            PH_DONE, PH_INVALID: ;
            default: ;
        endcase

        // status from the phase after this byte
        case (n_phase)
            PH_INVALID: status = wav_pkg::STS_INVALID;
            PH_DONE:    status = wav_pkg::STS_DATA_DONE;
            PH_DATA:    status = wav_pkg::STS_DATA;
            default:    status = wav_pkg::STS_HEADER;
        endcase
        if (i_last && (status == wav_pkg::STS_HEADER || status == wav_pkg::STS_DATA)) begin
            status = wav_pkg::STS_TRUNCATED;
        end
        o_result.parse_status  = status;
        o_result.channel_count = n_seen ? n_chan : 16'd0;
        o_result.rate_hz       = n_seen ? n_rate : 32'd0;
    end

    // state registers; the final byte of a stream returns everything to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase <= PH_RIFF_TAG;
            r_kind  <= KIND_OTHER;
            r_cnt   <= '0;
            r_shift <= '0;
            r_riff  <= '0;
            r_chunk <= '0;
            r_seen  <= 1'b0;
            r_code  <= '0;
            r_chan  <= '0;
            r_rate  <= '0;
            r_bits  <= '0;
            r_data  <= '0;
            r_hold  <= '0;
            r_held  <= 1'b0;
            r_body  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_riff  <= n_riff;
            r_chunk <= n_chunk;
            r_seen  <= n_seen;
            r_code  <= n_code;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_data  <= n_data;
            r_hold  <= n_hold;
            r_held  <= n_held;
            r_body  <= n_body;
        end
    end

endmodule

/* hdl/wav_riff_stream_deframer.sv */
// top level of the riff/wave pcm16 stream deframer
//
// Takes a wav file one byte per word on the input channel (i_valid/o_ready),
// with i_stream_last marking the final byte of the file. Every input word
// gives exactly one result word on the output channel (o_valid/i_ready):
// the sample completed on that byte if any, the accepted channel count and
// sample rate, and the parse status (header, data, data done, invalid,
// truncated).
// A result appears in the cycle after its byte is accepted.
// One byte is taken per cycle while o_ready is high; the parser state updates
// in the cycle the byte is taken and the result lands in a single output register.
// When the receiver stalls, the output register holds its word and o_ready
// falls, so the input stalls in the same cycle; o_ready is high whenever the
// output register is empty or being emptied.
// Reset clears the parser to expect a riff tag and empties the output
// register. After the byte with i_stream_last set, the parser returns to the
// same state, so the next byte starts a new file.
module wav_riff_stream_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_in_byte,
    input  logic               i_stream_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_pcm_sample,
    output logic               o_pcm_valid,
    output logic [15:0]        o_channel_count,
    output logic [31:0]        o_rate_hz,
    output logic [2:0]         o_parse_status
);

    wav_pkg::t_result res;
    wav_pkg::t_result r_out;
    logic             r_out_valid;
    logic             accept;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // parser core
    wav_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_byte   (i_in_byte),
        .i_last   (i_stream_last),
        .o_result (res)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pcm_sample    = r_out.pcm_sample;
    assign o_pcm_valid     = r_out.pcm_valid;
    assign o_channel_count = r_out.channel_count;
    assign o_rate_hz       = r_out.rate_hz;
    assign o_parse_status  = r_out.parse_status;

    // a sample only comes out of the data phase
    a_sample_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pcm_valid |->
            o_parse_status == wav_pkg::STS_DATA || o_parse_status == wav_pkg::STS_DATA_DONE ||
            o_parse_status == wav_pkg::STS_TRUNCATED)
        else $error("sample with header or invalid status");

    // no sample means a zero sample field
    a_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pcm_valid |-> o_pcm_sample == 16'sd0)
        else $error("nonzero sample without pcm_valid");

    // format fields are shown together or not at all
    a_format_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_channel_count == 16'd0) == (o_rate_hz == 32'd0))
        else $error("channel count and rate disagree");

    // output register is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule
